>>> sv/ppc_pkg.sv
package ppc_pkg;

  // Sizes of the vertex store and the output budget.
  localparam int MAX_VERTICES = 32;
  localparam int EXTRA_OUTPUT = 4;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = 6;
  localparam int EMIT_W       = 7;
  localparam int ADDR_W       = IDX_W + 1;

  // Vertex classes.
  localparam logic [1:0] CL_FRONT = 2'd0;
  localparam logic [1:0] CL_BACK  = 2'd1;
  localparam logic [1:0] CL_ON    = 2'd2;

  // Polygon outcome codes.
  localparam logic [2:0] OC_CLIPPED   = 3'd0;
  localparam logic [2:0] OC_UNCHANGED = 3'd1;
  localparam logic [2:0] OC_AWAY      = 3'd2;
  localparam logic [2:0] OC_ON_PLANE  = 3'd3;
  localparam logic [2:0] OC_OVERFLOW  = 3'd4;

  // Configuration register indexes.
  localparam logic [2:0] REG_NORM_X    = 3'd0;
  localparam logic [2:0] REG_NORM_Y    = 3'd1;
  localparam logic [2:0] REG_NORM_Z    = 3'd2;
  localparam logic [2:0] REG_OFFSET    = 3'd3;
  localparam logic [2:0] REG_TOLERANCE = 3'd4;

  localparam logic signed [39:0] POS40          = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] NEG40          = 40'sh80_0000_0000;
  localparam logic signed [17:0] NORM_ONE       = 18'sd65536;
  localparam logic signed [17:0] NORM_MINUS_ONE = -18'sd65536;

  typedef struct packed {
    logic signed [39:0] vertex_x;
    logic signed [39:0] vertex_y;
    logic signed [39:0] vertex_z;
    logic signed [39:0] tex_s;
    logic signed [39:0] tex_t;
    logic               last_vertex;
  } in_vertex_t;

  typedef struct packed {
    logic signed [39:0] out_x;
    logic signed [39:0] out_y;
    logic signed [39:0] out_z;
    logic signed [39:0] out_s;
    logic signed [39:0] out_t;
    logic               vertex_valid;
    logic [2:0]         outcome;
    logic               last_result;
  } out_result_t;

  typedef struct packed {
    logic signed [17:0] norm_x;
    logic signed [17:0] norm_y;
    logic signed [17:0] norm_z;
    logic signed [39:0] offset;
    logic [16:0]        tol;
  } plane_t;

  // One stored vertex with its distance and class.
  typedef struct packed {
    logic signed [39:0] x;
    logic signed [39:0] y;
    logic signed [39:0] z;
    logic signed [39:0] s;
    logic signed [39:0] t;
    logic signed [39:0] d;
    logic [1:0]         cls;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    entry_t            entry;
  } mem_wr_t;

  // Summary of one loaded polygon, handed from the front to the back end.
  typedef struct packed {
    logic              bank;
    logic [CNT_W-1:0]  n;
    logic [2:0]        oc;
    logic [EMIT_W-1:0] cnt;
  } desc_t;

  typedef struct packed {
    logic en;
    logic bank;
  } bank_free_t;

  // Saturate a wide signed value to 40 bits.
  function automatic logic signed [39:0] sat40(input logic signed [43:0] v);
    logic signed [39:0] r;
    if (v > 44'(POS40)) begin
      r = POS40;
    end else if (v < 44'(NEG40)) begin
      r = NEG40;
    end else begin
      r = v[39:0];
    end
    return r;
  endfunction

endpackage

>>> sv/polygon_plane_clipper.sv
// Clips one polygon against a single plane and emits the part behind it.
// Vertices are taken one per cycle while busy is low; a three-stage distance
// pipeline classifies each one into a two-bank vertex store, so a new polygon
// can load while the previous one is still being emitted. busy rises only
// when both banks hold polygons that are not yet fully emitted. After the
// last vertex the emit sequencer walks the store; each crossing edge is
// interpolated by the shared bit-serial divider, one coordinate at a time
// for all five coordinates. Outcome-only polygons produce their single
// result once their descriptor reaches the emit sequencer. Results appear
// on out_result for exactly one cycle with out_valid high and cannot be
// held off by the receiver.
module polygon_plane_clipper (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  ppc_pkg::in_vertex_t  in_vertex,
  output logic                 out_valid,
  output ppc_pkg::out_result_t out_result,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [39:0]          cfg_wdata
);

  ppc_pkg::plane_t     plane_r;
  ppc_pkg::mem_wr_t    mem_wr;
  ppc_pkg::desc_t      push_desc, head_desc;
  ppc_pkg::bank_free_t bank_free;
  logic push, head_valid, pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r.norm_x <= '0;
      plane_r.norm_y <= '0;
      plane_r.norm_z <= ppc_pkg::NORM_ONE;
      plane_r.offset <= '0;
      plane_r.tol    <= 17'd6;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ppc_pkg::REG_NORM_X:    plane_r.norm_x <= cfg_wdata[17:0];
        ppc_pkg::REG_NORM_Y:    plane_r.norm_y <= cfg_wdata[17:0];
        ppc_pkg::REG_NORM_Z:    plane_r.norm_z <= cfg_wdata[17:0];
        ppc_pkg::REG_OFFSET:    plane_r.offset <= cfg_wdata;
        ppc_pkg::REG_TOLERANCE: plane_r.tol    <= cfg_wdata[16:0];
        default: ;
      endcase
    end
  end

  ppc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_vertex (in_vertex),
    .busy      (busy),
    .plane     (plane_r),
    .mem_wr    (mem_wr),
    .push      (push),
    .push_desc (push_desc),
    .bank_free (bank_free)
  );

  ppc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  ppc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .plane      (plane_r),
    .mem_wr     (mem_wr),
    .q_valid    (head_valid),
    .q_desc     (head_desc),
    .q_pop      (pop),
    .bank_free  (bank_free),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  // An outcome-only transaction carries no vertex and closes the polygon.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.outcome >= ppc_pkg::OC_AWAY
      |-> out_result.last_result && !out_result.vertex_valid)
    else $error("outcome-only result malformed");

  // A vertex transaction belongs to a clipped or unchanged polygon.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result.vertex_valid
      |-> out_result.outcome == ppc_pkg::OC_CLIPPED ||
          out_result.outcome == ppc_pkg::OC_UNCHANGED)
    else $error("vertex result with outcome-only code");

  // Reset silences the result channel.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule

>>> sv/ppc_queue.sv
module ppc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ppc_pkg::desc_t push_desc,
  input  logic           pop,
  output logic           head_valid,
  output ppc_pkg::desc_t head_desc
);

  ppc_pkg::desc_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] fill_r;

  assign head_valid = (fill_r != 2'd0);
  assign head_desc  = ent_r[rp_r];

  // Two-entry descriptor FIFO; at most two polygons own a store bank.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_desc;
    end
  end

endmodule

>>> sv/ppc_front.sv
module ppc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ppc_pkg::in_vertex_t in_vertex,
  output logic                busy,
  input  ppc_pkg::plane_t     plane,
  output ppc_pkg::mem_wr_t    mem_wr,
  output logic                push,
  output ppc_pkg::desc_t      push_desc,
  input  ppc_pkg::bank_free_t bank_free
);

  typedef struct packed {
    logic                      valid;
    logic                      drop;
    logic                      bank;
    logic [ppc_pkg::IDX_W-1:0] idx;
    ppc_pkg::in_vertex_t       v;
  } stage_t;

  localparam int EMIT_W = ppc_pkg::EMIT_W;

  logic accept;
  logic [ppc_pkg::CNT_W-1:0] wcnt_r;
  logic       wbank_r;
  logic [1:0] bank_busy_r;

  stage_t s0_r, s1_r, s2_r;
  logic signed [57:0] px_r, py_r, pz_r;
  logic signed [59:0] acc_r;

  assign busy   = bank_busy_r[wbank_r];
  assign accept = start && !busy;

  // Accept side: assign store slots and claim a bank per polygon.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wcnt_r      <= '0;
      wbank_r     <= 1'b0;
      bank_busy_r <= 2'b00;
    end else begin
      if (bank_free.en) begin
        bank_busy_r[bank_free.bank] <= 1'b0;
      end
      if (accept) begin
        if (in_vertex.last_vertex) begin
          wcnt_r               <= '0;
          wbank_r              <= ~wbank_r;
          bank_busy_r[wbank_r] <= 1'b1;
        end else if (wcnt_r < ppc_pkg::CNT_W'(ppc_pkg::MAX_VERTICES)) begin
          wcnt_r <= wcnt_r + 1'b1;
        end
      end
    end
  end

  // Distance pipeline: products, then sum, then classify.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
    end else begin
      s0_r.valid <= accept;
      s1_r.valid <= s0_r.valid;
      s2_r.valid <= s1_r.valid;
    end
    s0_r.drop <= (wcnt_r >= ppc_pkg::CNT_W'(ppc_pkg::MAX_VERTICES));
    s0_r.bank <= wbank_r;
    s0_r.idx  <= wcnt_r[ppc_pkg::IDX_W-1:0];
    s0_r.v    <= in_vertex;
    s1_r.drop <= s0_r.drop;
    s1_r.bank <= s0_r.bank;
    s1_r.idx  <= s0_r.idx;
    s1_r.v    <= s0_r.v;
    s2_r.drop <= s1_r.drop;
    s2_r.bank <= s1_r.bank;
    s2_r.idx  <= s1_r.idx;
    s2_r.v    <= s1_r.v;
    px_r  <= 58'(s0_r.v.vertex_x) * 58'(plane.norm_x);
    py_r  <= 58'(s0_r.v.vertex_y) * 58'(plane.norm_y);
    pz_r  <= 58'(s0_r.v.vertex_z) * 58'(plane.norm_z);
    acc_r <= 60'(px_r) + 60'(py_r) + 60'(pz_r)
           - 60'($signed({plane.offset, 16'h0000})) + 60'sd32768;
  end

  // Classification of the vertex leaving the pipeline.
  logic signed [39:0] vtx_dist;
  logic signed [41:0] dist42, tol42;
  logic [1:0] cls;

  always_comb begin
    vtx_dist = ppc_pkg::sat40(acc_r[59:16]);
    dist42   = 42'(vtx_dist);
    tol42    = $signed({25'd0, plane.tol});
    if (dist42 > tol42) begin
      cls = ppc_pkg::CL_FRONT;
    end else if (dist42 < -tol42) begin
      cls = ppc_pkg::CL_BACK;
    end else begin
      cls = ppc_pkg::CL_ON;
    end
  end

  assign mem_wr.we          = s2_r.valid && !s2_r.drop;
  assign mem_wr.addr        = {s2_r.bank, s2_r.idx};
  assign mem_wr.entry.x     = s2_r.v.vertex_x;
  assign mem_wr.entry.y     = s2_r.v.vertex_y;
  assign mem_wr.entry.z     = s2_r.v.vertex_z;
  assign mem_wr.entry.s     = s2_r.v.tex_s;
  assign mem_wr.entry.t     = s2_r.v.tex_t;
  assign mem_wr.entry.d     = vtx_dist;
  assign mem_wr.entry.cls   = cls;

  // Per-polygon statistics, including the number of output vertices.
  logic [ppc_pkg::CNT_W-1:0] n_r, cf_r, cb_r, con_r, cross_r;
  logic [ppc_pkg::CNT_W-1:0] n_nxt, cf_nxt, cb_nxt, con_nxt, cross_nxt;
  logic ovf_r, ovf_nxt;
  logic [1:0] first_cls_r, first_cls_nxt, prev_cls_r, prev_cls_nxt;
  logic wrap;
  logic [ppc_pkg::EMIT_W-1:0] emit_cnt;
  logic [2:0] oc;

  always_comb begin
    n_nxt         = n_r;
    cf_nxt        = cf_r;
    cb_nxt        = cb_r;
    con_nxt       = con_r;
    cross_nxt     = cross_r;
    ovf_nxt       = ovf_r;
    first_cls_nxt = first_cls_r;
    prev_cls_nxt  = prev_cls_r;
    if (s2_r.valid) begin
      if (s2_r.drop) begin
        ovf_nxt = 1'b1;
      end else begin
        n_nxt = n_r + 1'b1;
        case (cls)
          ppc_pkg::CL_FRONT: cf_nxt  = cf_r + 1'b1;
          ppc_pkg::CL_BACK:  cb_nxt  = cb_r + 1'b1;
          default:           con_nxt = con_r + 1'b1;
        endcase
        if (n_r == '0) begin
          first_cls_nxt = cls;
        end else if (prev_cls_r != ppc_pkg::CL_ON && cls != ppc_pkg::CL_ON &&
                     prev_cls_r != cls) begin
          cross_nxt = cross_r + 1'b1;
        end
        prev_cls_nxt = cls;
      end
    end
    // Closing edge from the last stored vertex back to the first.
    wrap = prev_cls_nxt != ppc_pkg::CL_ON && first_cls_nxt != ppc_pkg::CL_ON &&
           prev_cls_nxt != first_cls_nxt;
    emit_cnt = EMIT_W'(cb_nxt) + EMIT_W'(con_nxt) + EMIT_W'(cross_nxt)
             + EMIT_W'(wrap);
    if (ovf_nxt) begin
      oc = ppc_pkg::OC_OVERFLOW;
    end else if (cb_nxt == '0 && cf_nxt == '0) begin
      oc = ppc_pkg::OC_ON_PLANE;
    end else if (cb_nxt == '0) begin
      oc = ppc_pkg::OC_AWAY;
    end else if (cf_nxt == '0) begin
      oc = ppc_pkg::OC_UNCHANGED;
    end else if (emit_cnt > EMIT_W'(n_nxt) + EMIT_W'(ppc_pkg::EXTRA_OUTPUT)) begin
      oc = ppc_pkg::OC_OVERFLOW;
    end else begin
      oc = ppc_pkg::OC_CLIPPED;
    end
  end

  assign push           = s2_r.valid && s2_r.v.last_vertex;
  assign push_desc.bank = s2_r.bank;
  assign push_desc.n    = n_nxt;
  assign push_desc.oc   = oc;
  assign push_desc.cnt  = emit_cnt;

  always_ff @(posedge clk) begin
    if (!rst_n || push) begin
      n_r     <= '0;
      cf_r    <= '0;
      cb_r    <= '0;
      con_r   <= '0;
      cross_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      n_r     <= n_nxt;
      cf_r    <= cf_nxt;
      cb_r    <= cb_nxt;
      con_r   <= con_nxt;
      cross_r <= cross_nxt;
      ovf_r   <= ovf_nxt;
    end
    first_cls_r <= first_cls_nxt;
    prev_cls_r  <= prev_cls_nxt;
  end

endmodule

>>> sv/ppc_lerp.sv
module ppc_lerp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [39:0] p0,
  input  logic signed [39:0] p1,
  input  logic [40:0]        ud0,
  input  logic [40:0]        uden,
  output logic               done,
  output logic signed [39:0] res
);

  // Computes p0 + sign(p1-p0) * round(|p1-p0| * ud0 / uden), one
  // multiplicand bit per cycle with a quotient digit of 0, 1 or 2.
  localparam logic [5:0] STEPS = 6'd40;

  logic               busy_r, done_r, neg_r;
  logic [5:0]         cnt_r;
  logic [39:0]        ad_r;
  logic [40:0]        r_r, q_r, ud0_r, den_r;
  logic signed [39:0] p0_r, res_r;

  logic signed [40:0] delta;
  logic [40:0]        delta_abs;
  logic [42:0]        t, den1, den2;
  logic [1:0]         dig;
  logic [40:0]        off;
  logic signed [43:0] sum;

  assign done = done_r;
  assign res  = res_r;

  always_comb begin
    delta     = 41'(p1) - 41'(p0);
    delta_abs = delta[40] ? 41'(-delta) : 41'(delta);
    den1      = {2'b00, den_r};
    den2      = {1'b0, den_r, 1'b0};
    t         = {1'b0, r_r, 1'b0} + (ad_r[39] ? {2'b00, ud0_r} : 43'd0);
    dig       = 2'd0;
    if (t >= den2) begin
      t   = t - den2;
      dig = 2'd2;
    end else if (t >= den1) begin
      t   = t - den1;
      dig = 2'd1;
    end
    // Round half up on the final remainder.
    off = q_r + (({1'b0, r_r} << 1) >= {1'b0, den_r} ? 41'd1 : 41'd0);
    sum = neg_r ? 44'(p0_r) - 44'(off) : 44'(p0_r) + 44'(off);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
    if (start) begin
      cnt_r <= STEPS;
      ad_r  <= delta_abs[39:0];
      neg_r <= delta[40];
      p0_r  <= p0;
      ud0_r <= ud0;
      den_r <= uden;
      r_r   <= '0;
      q_r   <= '0;
    end else if (busy_r && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
      ad_r  <= {ad_r[38:0], 1'b0};
      r_r   <= t[40:0];
      q_r   <= {q_r[39:0], 1'b0} + {39'd0, dig};
    end else if (busy_r) begin
      res_r <= ppc_pkg::sat40(sum);
    end
  end

endmodule

>>> sv/ppc_back.sv
module ppc_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ppc_pkg::plane_t      plane,
  input  ppc_pkg::mem_wr_t     mem_wr,
  input  logic                 q_valid,
  input  ppc_pkg::desc_t       q_desc,
  output logic                 q_pop,
  output ppc_pkg::bank_free_t  bank_free,
  output logic                 out_valid,
  output ppc_pkg::out_result_t out_result
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_VISIT = 3'd2;
  localparam logic [2:0] S_NEXT  = 3'd3;
  localparam logic [2:0] S_EDGE  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;

  localparam int DEPTH = 2 * ppc_pkg::MAX_VERTICES;

  // Vertex store, two banks of one polygon each.
  ppc_pkg::entry_t mem [DEPTH];
  ppc_pkg::entry_t rd_data_r;
  logic                       rd_en;
  logic [ppc_pkg::ADDR_W-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (mem_wr.we) begin
      mem[mem_wr.addr] <= mem_wr.entry;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  logic [2:0] state_r, state_nxt;
  ppc_pkg::desc_t desc_r, desc_nxt;
  ppc_pkg::entry_t a_r, a_nxt, b_r, b_nxt, first_r, first_nxt;
  logic [ppc_pkg::IDX_W-1:0]  i_r, i_nxt;
  logic [ppc_pkg::EMIT_W-1:0] e_r, e_nxt;
  logic [2:0]                 k_r, k_nxt;
  logic signed [39:0]         res_r [4];
  logic signed [39:0]         res_nxt [4];
  logic                       out_valid_r, out_valid_nxt;
  ppc_pkg::out_result_t       out_r, out_nxt;

  logic               lerp_start, lerp_done;
  logic signed [39:0] lerp_p0, lerp_p1, lerp_res;
  logic [40:0]        ud0, uden;
  logic signed [40:0] den;
  logic               is_last_idx, crossing;
  logic signed [39:0] neg_off;

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // Edge operands for the shared interpolation unit.
  always_comb begin
    den  = 41'(a_r.d) - 41'(b_r.d);
    uden = den[40] ? 41'(-den) : 41'(den);
    ud0  = a_r.d[39] ? 41'(-41'(a_r.d)) : 41'(a_r.d);
    neg_off  = ppc_pkg::sat40(-44'(plane.offset));
    crossing = a_r.cls != ppc_pkg::CL_ON && b_r.cls != ppc_pkg::CL_ON &&
               a_r.cls != b_r.cls;
  end

  // The coordinate handed to the divider is the one it starts on this cycle.
  always_comb begin
    case (k_nxt)
      3'd0: begin
        lerp_p0 = a_r.x;
        lerp_p1 = b_r.x;
      end
      3'd1: begin
        lerp_p0 = a_r.y;
        lerp_p1 = b_r.y;
      end
      3'd2: begin
        lerp_p0 = a_r.z;
        lerp_p1 = b_r.z;
      end
      3'd3: begin
        lerp_p0 = a_r.s;
        lerp_p1 = b_r.s;
      end
      default: begin
        lerp_p0 = a_r.t;
        lerp_p1 = b_r.t;
      end
    endcase
  end

  ppc_lerp u_lerp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (lerp_start),
    .p0    (lerp_p0),
    .p1    (lerp_p1),
    .ud0   (ud0),
    .uden  (uden),
    .done  (lerp_done),
    .res   (lerp_res)
  );

  // Snap a coordinate to the plane for an axial normal.
  function automatic logic signed [39:0] snap(input logic signed [17:0] nrm,
                                               input logic signed [39:0] off,
                                               input logic signed [39:0] noff,
                                               input logic signed [39:0] v);
    logic signed [39:0] r;
    if (nrm == ppc_pkg::NORM_ONE) begin
      r = off;
    end else if (nrm == ppc_pkg::NORM_MINUS_ONE) begin
      r = noff;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Emit sequencer: walk the stored polygon and produce result transactions.
  always_comb begin
    state_nxt     = state_r;
    desc_nxt      = desc_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    first_nxt     = first_r;
    i_nxt         = i_r;
    e_nxt         = e_r;
    k_nxt         = k_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    rd_en         = 1'b0;
    rd_addr       = {desc_r.bank, i_r + 1'b1};
    q_pop         = 1'b0;
    bank_free.en  = 1'b0;
    bank_free.bank = desc_r.bank;
    lerp_start    = 1'b0;
    is_last_idx   = (ppc_pkg::CNT_W'(i_r) + 1'b1) == desc_r.n;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop    = 1'b1;
          desc_nxt = q_desc;
          i_nxt    = '0;
          e_nxt    = '0;
          if (q_desc.oc >= ppc_pkg::OC_AWAY) begin
            out_valid_nxt = 1'b1;
            out_nxt       = '0;
            out_nxt.outcome     = q_desc.oc;
            out_nxt.last_result = 1'b1;
            bank_free.en   = 1'b1;
            bank_free.bank = q_desc.bank;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = {q_desc.bank, {ppc_pkg::IDX_W{1'b0}}};
            state_nxt = S_FETCH;
          end
        end
      end
      S_FETCH: begin
        a_nxt     = rd_data_r;
        first_nxt = rd_data_r;
        state_nxt = S_VISIT;
      end
      S_VISIT: begin
        out_nxt.out_x        = a_r.x;
        out_nxt.out_y        = a_r.y;
        out_nxt.out_z        = a_r.z;
        out_nxt.out_s        = a_r.s;
        out_nxt.out_t        = a_r.t;
        out_nxt.vertex_valid = 1'b1;
        out_nxt.outcome      = desc_r.oc;
        if (desc_r.oc == ppc_pkg::OC_UNCHANGED) begin
          out_valid_nxt       = 1'b1;
          out_nxt.last_result = is_last_idx;
          if (is_last_idx) begin
            bank_free.en = 1'b1;
            state_nxt    = S_IDLE;
          end else begin
            rd_en     = 1'b1;
            state_nxt = S_NEXT;
          end
        end else begin
          if (a_r.cls != ppc_pkg::CL_FRONT) begin
            out_valid_nxt       = 1'b1;
            out_nxt.last_result = (e_r + 1'b1) == desc_r.cnt;
            e_nxt               = e_r + 1'b1;
          end
          if (is_last_idx) begin
            b_nxt     = first_r;
            state_nxt = S_EDGE;
          end else begin
            rd_en     = 1'b1;
            state_nxt = S_NEXT;
          end
        end
      end
      S_NEXT: begin
        if (desc_r.oc == ppc_pkg::OC_UNCHANGED) begin
          a_nxt     = rd_data_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_VISIT;
        end else begin
          b_nxt     = rd_data_r;
          state_nxt = S_EDGE;
        end
      end
      S_EDGE: begin
        if (crossing) begin
          k_nxt      = '0;
          lerp_start = 1'b1;
          state_nxt  = S_DIV;
        end else if (is_last_idx) begin
          bank_free.en = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          a_nxt     = b_r;
          i_nxt     = i_r + 1'b1;
          state_nxt = S_VISIT;
        end
      end
      S_DIV: begin
        if (lerp_done) begin
          if (k_r == 3'd4) begin
            out_valid_nxt        = 1'b1;
            out_nxt.out_x        = snap(plane.norm_x, plane.offset, neg_off, res_r[0]);
            out_nxt.out_y        = snap(plane.norm_y, plane.offset, neg_off, res_r[1]);
            out_nxt.out_z        = snap(plane.norm_z, plane.offset, neg_off, res_r[2]);
            out_nxt.out_s        = res_r[3];
            out_nxt.out_t        = lerp_res;
            out_nxt.vertex_valid = 1'b1;
            out_nxt.outcome      = desc_r.oc;
            out_nxt.last_result  = (e_r + 1'b1) == desc_r.cnt;
            e_nxt                = e_r + 1'b1;
            if (is_last_idx) begin
              bank_free.en = 1'b1;
              state_nxt    = S_IDLE;
            end else begin
              a_nxt     = b_r;
              i_nxt     = i_r + 1'b1;
              state_nxt = S_VISIT;
            end
          end else begin
            res_nxt[k_r[1:0]] = lerp_res;
            k_nxt             = k_r + 1'b1;
            lerp_start        = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    desc_r  <= desc_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    first_r <= first_nxt;
    i_r     <= i_nxt;
    e_r     <= e_nxt;
    k_r     <= k_nxt;
    res_r   <= res_nxt;
    out_r   <= out_nxt;
  end

endmodule
